>>> sv/cfb_pkg.sv
// ============================================================================
// cfb_pkg: shared types and constants of the circular FIFO buffer
// Sizes, action codes, controller states and the command and status bundles
// that join the controller to the datapath.
// ============================================================================
`default_nettype none

package cfb_pkg;

  // Storage and word sizes.
  localparam int Depth     = 256;
  localparam int WordWidth = 32;
  localparam int PtrW      = $clog2(Depth);
  localparam int NW        = PtrW + 1;

  // Port field widths.
  localparam int DataW    = 32;
  localparam int ActW     = 2;
  localparam int SlotsW   = 9;
  localparam int HeldW    = 8;
  localparam int OutDataW = 48;

  localparam logic [SlotsW-1:0] SlotsReset = SlotsW'(Depth);
  localparam logic [NW-1:0]     HeldMax    = NW'(255);

  // Action codes; the unused code behaves as a status query.
  localparam logic [ActW-1:0] ActWrite  = 2'd0;
  localparam logic [ActW-1:0] ActRead   = 2'd1;
  localparam logic [ActW-1:0] ActStatus = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RDWAIT
  } state_e;

  typedef struct packed {
    logic exec;        // perform the accepted access this cycle
    logic load_rdata;  // copy the memory read word into the result
  } cfb_cmd_t;

  typedef struct packed {
    logic rd_hit;      // the presented access is a read that finds data
  } cfb_status_t;

  // Advance a ring index by one, wrapping to zero at the slot count.
  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] idx,
                                                input logic [NW-1:0]   n);
    logic [NW-1:0] v;
    v = {1'b0, idx} + NW'(1);
    return (v >= n) ? '0 : v[PtrW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/circular_fifo_buffer.sv
// ============================================================================
// circular_fifo_buffer: ring FIFO with write, read and status accesses
// Top level joining the handshake controller and the storage datapath.
// ============================================================================
// Each input word carries an access: write appends write_data unless the
// ring is full, read removes and returns the oldest word (zero and not
// accepted when empty), and status (or the unused code) changes nothing.
// Every access produces exactly one output word with the read data, the
// accepted flag, the full flag and the fill level after the access. The
// ring uses slots_in_use slots (clamped to 2..256) and always leaves one
// empty, so it holds at most slots_in_use - 1 words; writing the register
// empties the ring. Writes and status accesses load the result register
// directly, while a successful read first passes the registered read port
// of the slot memory and no new access is taken meanwhile. The result sits
// in an output register, so a new access is taken in the same cycle the
// previous result is consumed. The slot memory needs no clearing after
// reset: a slot is only read after it has been written.
// ============================================================================
`default_nettype none

module circular_fifo_buffer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Slot count register.
  input  wire logic                           cfg_we_i,
  input  wire logic [cfb_pkg::SlotsW-1:0]     cfg_wdata_i,
  // Access stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [cfb_pkg::DataW-1:0]      s_axis_tdata,   // [31:0] write_data
  input  wire logic [cfb_pkg::ActW-1:0]       s_axis_tuser,   // [1:0] action
  // Result stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] read_data, [32] accepted, [33] is_full, [41:34] words_held,
  // [47:42] zero
  output logic [cfb_pkg::OutDataW-1:0]        m_axis_tdata
);

  cfb_pkg::cfb_cmd_t    cmd;
  cfb_pkg::cfb_status_t status;

  logic [cfb_pkg::DataW-1:0] read_data;
  logic                      accepted;
  logic                      is_full;
  logic [cfb_pkg::HeldW-1:0] words_held;

  cfb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  cfb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (s_axis_tuser),
    .write_data_i (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (read_data),
    .accepted_o   (accepted),
    .is_full_o    (is_full),
    .words_held_o (words_held)
  );

  // Pack the result fields from the lowest bit up; the top bits pad to bytes.
  assign m_axis_tdata = {6'd0, words_held, is_full, accepted, read_data};

endmodule

`default_nettype wire

>>> sv/cfb_ctrl.sv
// ============================================================================
// cfb_ctrl: controller of the circular FIFO buffer
// Handles both stream handshakes and sequences the datapath.
// ============================================================================
`default_nettype none

module cfb_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire cfb_pkg::cfb_status_t status_i,
  output cfb_pkg::cfb_cmd_t         cmd_o
);

  cfb_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign accept = s_axis_tvalid & s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cfb_pkg::ST_IDLE: begin
        if (accept && status_i.rd_hit) begin
          state_d = cfb_pkg::ST_RDWAIT;
        end
      end
      cfb_pkg::ST_RDWAIT: begin
        state_d = cfb_pkg::ST_IDLE;
      end
      default: begin
        state_d = cfb_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and result-valid tracking.
  always_comb begin
    s_axis_tready    = 1'b0;
    cmd_o.exec       = 1'b0;
    cmd_o.load_rdata = 1'b0;
    out_valid_d      = out_valid_q & ~m_axis_tready;
    case (state_q)
      cfb_pkg::ST_IDLE: begin
        s_axis_tready = ~out_valid_q | m_axis_tready;
        cmd_o.exec    = accept;
        if (accept && !status_i.rd_hit) begin
          out_valid_d = 1'b1;
        end
      end
      cfb_pkg::ST_RDWAIT: begin
        cmd_o.load_rdata = 1'b1;
        out_valid_d      = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/cfb_datapath.sv
// ============================================================================
// cfb_datapath: ring storage, pointers and result register
// Holds the slot memory, head and tail indexes, the slot count register and
// the registered result word.
// ============================================================================
`default_nettype none

module cfb_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cfb_pkg::SlotsW-1:0]    cfg_wdata_i,
  input  wire logic [cfb_pkg::ActW-1:0]      action_i,
  input  wire logic [cfb_pkg::DataW-1:0]     write_data_i,
  input  wire cfb_pkg::cfb_cmd_t             cmd_i,
  output cfb_pkg::cfb_status_t               status_o,
  output logic [cfb_pkg::DataW-1:0]          read_data_o,
  output logic                               accepted_o,
  output logic                               is_full_o,
  output logic [cfb_pkg::HeldW-1:0]          words_held_o
);

  localparam int PtrW = cfb_pkg::PtrW;
  localparam int NW   = cfb_pkg::NW;
  localparam int WW   = cfb_pkg::WordWidth;

  logic [WW-1:0] mem_q [cfb_pkg::Depth];
  logic [WW-1:0] rdata_q;

  logic [cfb_pkg::SlotsW-1:0] slots_q;
  logic [PtrW-1:0] head_q, tail_q;
  logic [PtrW-1:0] head_n, tail_n, tail_inc, head_inc;
  logic [NW-1:0]   n_eff;
  logic            wr_ok, rd_ok;
  logic [NW-1:0]   held;
  logic [NW-1:0]   held_sat;

  logic [cfb_pkg::DataW-1:0] res_data_q;
  logic                      res_ok_q, res_full_q;
  logic [cfb_pkg::HeldW-1:0] res_held_q;

  // Effective slot count, clamped to the range two up to the memory depth.
  always_comb begin
    if (slots_q < cfb_pkg::SlotsW'(2)) begin
      n_eff = NW'(2);
    end else if (slots_q > cfb_pkg::SlotsW'(cfb_pkg::Depth)) begin
      n_eff = NW'(cfb_pkg::Depth);
    end else begin
      n_eff = NW'(slots_q);
    end
  end

  always_comb begin
    tail_inc = cfb_pkg::next_slot(tail_q, n_eff);
    head_inc = cfb_pkg::next_slot(head_q, n_eff);
    wr_ok    = (action_i == cfb_pkg::ActWrite) && (tail_inc != head_q);
    rd_ok    = (action_i == cfb_pkg::ActRead) && (head_q != tail_q);
    tail_n   = wr_ok ? tail_inc : tail_q;
    head_n   = rd_ok ? head_inc : head_q;
    if (tail_n >= head_n) begin
      held = NW'(tail_n) - NW'(head_n);
    end else begin
      held = n_eff + NW'(tail_n) - NW'(head_n);
    end
    held_sat = (held > cfb_pkg::HeldMax) ? cfb_pkg::HeldMax : held;
  end

  assign status_o.rd_hit = rd_ok;

  // Pointers and slot count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= cfb_pkg::SlotsReset;
      head_q  <= '0;
      tail_q  <= '0;
    end else if (cfg_we_i) begin
      slots_q <= cfg_wdata_i;
      head_q  <= '0;
      tail_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_n;
      tail_q <= tail_n;
    end
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_ok) begin
      mem_q[tail_q] <= write_data_i[WW-1:0];
    end
    if (cmd_i.exec && rd_ok) begin
      rdata_q <= mem_q[head_q];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_data_q <= '0;
      res_ok_q   <= wr_ok | rd_ok;
      res_full_q <= (cfb_pkg::next_slot(tail_n, n_eff) == head_n);
      res_held_q <= held_sat[cfb_pkg::HeldW-1:0];
    end else if (cmd_i.load_rdata) begin
      res_data_q <= cfb_pkg::DataW'(rdata_q);
    end
  end

  assign read_data_o  = res_data_q;
  assign accepted_o   = res_ok_q;
  assign is_full_o    = res_full_q;
  assign words_held_o = res_held_q;

endmodule

`default_nettype wire

>>> sim/tb_circular_fifo_buffer.sv
// ============================================================================
// tb_circular_fifo_buffer: self-checking bench for the circular FIFO buffer
// A short table of directed accesses, then phases of random write and read
// bursts under several slot counts, scored against typed-in results or a behavioral ring.
// ============================================================================
`default_nettype none

module tb_circular_fifo_buffer;

  // The package names three action codes; the fourth acts as a status query.
  localparam logic [cfb_pkg::ActW-1:0] ActSpare = 2'd3;

  // Layout of one result word, lowest field last.
  typedef struct packed {
    logic [5:0]                pad;
    logic [cfb_pkg::HeldW-1:0] held;
    logic                      full;
    logic                      acc;
    logic [cfb_pkg::DataW-1:0] rd;
  } fifo_word_t;

  // One row of the directed table: a slot count write, or one access with
  // an optional typed-in result.
  typedef struct packed {
    logic                       is_cfg;
    logic [cfb_pkg::SlotsW-1:0] slots;
    logic [cfb_pkg::ActW-1:0]   act;
    logic [cfb_pkg::DataW-1:0]  data;
    logic                       known;
    fifo_word_t                 want;
  } stim_row_t;

  localparam int NumDirRows = 29;
  localparam fifo_word_t Empty0 = '0;

  localparam stim_row_t DirRows [NumDirRows] = '{
    // Reset slot count: empty status, empty read, spare code.
    '{1'b0, 9'd0, cfb_pkg::ActStatus, 32'h0,         1'b1, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1, Empty0},
    '{1'b0, 9'd0, ActSpare,           32'hFFFF_FFFF, 1'b1, Empty0},
    // All-ones and all-zeros words in and out again.
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'hFFFF_FFFF, 1'b1,
      '{6'd0, 8'd1, 1'b0, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h0,         1'b1,
      '{6'd0, 8'd2, 1'b0, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1,
      '{6'd0, 8'd1, 1'b0, 1'b1, 32'hFFFF_FFFF}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1,
      '{6'd0, 8'd0, 1'b0, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1, Empty0},
    // Smallest ring: one word fills it, a second write is refused.
    '{1'b1, 9'd2, cfb_pkg::ActStatus, 32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'hA5A5_5A5A, 1'b1,
      '{6'd0, 8'd1, 1'b1, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h1234_5678, 1'b1,
      '{6'd0, 8'd1, 1'b1, 1'b0, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActStatus, 32'h0,         1'b1,
      '{6'd0, 8'd1, 1'b1, 1'b0, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1,
      '{6'd0, 8'd0, 1'b0, 1'b1, 32'hA5A5_5A5A}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1, Empty0},
    // Three slots: fill, refuse, and wrap both indexes.
    '{1'b1, 9'd3, cfb_pkg::ActStatus, 32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h8000_0001, 1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h7FFF_FFFE, 1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'hDEAD_BEEF, 1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h0F0F_0F0F, 1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b0, Empty0},
    // A slot count of zero is clamped up to two.
    '{1'b1, 9'd0, cfb_pkg::ActStatus, 32'h0,         1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h0000_FFFF, 1'b1,
      '{6'd0, 8'd1, 1'b1, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'hFFFF_0000, 1'b1,
      '{6'd0, 8'd1, 1'b1, 1'b0, 32'h0}},
    // The largest register value is clamped down to the storage depth.
    '{1'b1, 9'd511, cfb_pkg::ActStatus, 32'h0,       1'b0, Empty0},
    '{1'b0, 9'd0, cfb_pkg::ActWrite,  32'h3C3C_3C3C, 1'b1,
      '{6'd0, 8'd1, 1'b0, 1'b1, 32'h0}},
    '{1'b0, 9'd0, cfb_pkg::ActRead,   32'h0,         1'b1,
      '{6'd0, 8'd0, 1'b0, 1'b1, 32'h3C3C_3C3C}}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [cfb_pkg::SlotsW-1:0]   cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [cfb_pkg::DataW-1:0]    s_axis_tdata;   // [31:0] write_data
  logic [cfb_pkg::ActW-1:0]     s_axis_tuser;   // [1:0] action
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // [31:0] read_data, [32] accepted, [33] is_full, [41:34] words_held, [47:42] zero
  logic [cfb_pkg::OutDataW-1:0] m_axis_tdata;

  // Behavioral ring: storage, indexes and the slot count register.
  logic [cfb_pkg::DataW-1:0]  ring_mem [cfb_pkg::Depth];
  int unsigned                head_idx;
  int unsigned                tail_idx;
  logic [cfb_pkg::SlotsW-1:0] slot_count;

  fifo_word_t expected_words [$];
  int         err_count = 0;

  circular_fifo_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Slot count actually used by the ring, clamped to 2..Depth.
  function automatic int unsigned ring_len();
    int unsigned n;
    n = slot_count;
    if (n < 2) n = 2;
    if (n > cfb_pkg::Depth) n = cfb_pkg::Depth;
    return n;
  endfunction

  function automatic int unsigned wrap_inc(input int unsigned idx, input int unsigned n);
    return (idx + 1 >= n) ? 0 : idx + 1;
  endfunction

  // Applies one access to the behavioral ring and returns the result word.
  function automatic fifo_word_t fifo_access(input logic [cfb_pkg::ActW-1:0] act,
                                             input logic [cfb_pkg::DataW-1:0] data);
    fifo_word_t  r;
    int unsigned n;
    int unsigned cnt;
    r = '0;
    n = ring_len();
    if (head_idx >= n) head_idx = 0;
    if (tail_idx >= n) tail_idx = 0;
    case (act)
      cfb_pkg::ActWrite: begin
        if (wrap_inc(tail_idx, n) != head_idx) begin
          ring_mem[tail_idx] = data;
          tail_idx = wrap_inc(tail_idx, n);
          r.acc = 1'b1;
        end
      end
      cfb_pkg::ActRead: begin
        if (head_idx != tail_idx) begin
          r.rd = ring_mem[head_idx];
          head_idx = wrap_inc(head_idx, n);
          r.acc = 1'b1;
        end
      end
      default: ;
    endcase
    cnt = (tail_idx >= head_idx) ? tail_idx - head_idx : n + tail_idx - head_idx;
    if (cnt > 255) cnt = 255;
    r.held = cnt[cfb_pkg::HeldW-1:0];
    r.full = (wrap_inc(tail_idx, n) == head_idx);
    return r;
  endfunction

  // Offers one access word and waits until the buffer takes it.
  task automatic send_access(input logic [cfb_pkg::ActW-1:0] act,
                             input logic [cfb_pkg::DataW-1:0] data,
                             input logic known, input fifo_word_t want);
    fifo_word_t predicted;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = fifo_access(act, data);
    expected_words.push_back(known ? want : predicted);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain_results();
    hold_off(1);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Slot count writes happen only on an idle buffer; each one empties the ring.
  task automatic write_slots(input logic [cfb_pkg::SlotsW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    slot_count = value;
    head_idx   = 0;
    tail_idx   = 0;
  endtask

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    logic [cfb_pkg::SlotsW-1:0] phase_slots;
    logic [cfb_pkg::ActW-1:0]   act;
    int                         phase_items;
    int                         burst_left;
    int                         flip_left;
    int                         write_pct;
    int                         pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cfb_pkg::ActStatus;
    slot_count    = cfb_pkg::SlotsReset;
    head_idx      = 0;
    tail_idx      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].is_cfg) begin
        write_slots(DirRows[i].slots);
      end else begin
        send_access(DirRows[i].act, DirRows[i].data, DirRows[i].known, DirRows[i].want);
      end
    end

    // Random phases. The first one runs long at the full depth so the ring
    // can fill up; the others use tiny, clamped and random counts.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       phase_slots = 9'd256;
        1:       phase_slots = 9'd2;
        2:       phase_slots = 9'd3;
        3:       phase_slots = 9'd0;
        4:       phase_slots = 9'd511;
        5:       phase_slots = 9'd1;
        6:       phase_slots = 9'd257;
        7:       phase_slots = 9'($urandom_range(4, 24));
        8:       phase_slots = 9'($urandom_range(0, 511));
        default: phase_slots = 9'($urandom_range(5, 40));
      endcase
      write_slots(phase_slots);
      phase_items = (p == 0) ? 500 : 120;
      burst_left  = 0;
      flip_left   = 0;
      write_pct   = 80;
      for (int k = 0; k < phase_items; k++) begin
        // Alternate between filling and emptying so both the full and the
        // empty corners are reached, with the occasional status query.
        if (flip_left == 0) begin
          write_pct = (write_pct > 50) ? 25 : 80;
          flip_left = $urandom_range(1, 2 * (ring_len() - 1) + 2);
        end
        flip_left--;
        pick = $urandom_range(0, 99);
        if (pick < 5) act = cfb_pkg::ActStatus;
        else if (pick < 10) act = ActSpare;
        else act = ($urandom_range(0, 99) < write_pct) ? cfb_pkg::ActWrite : cfb_pkg::ActRead;

        if (burst_left == 0) begin
          hold_off(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_access(act, $urandom, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The receiver stalls on a rotating eight-bit mask, redrawn as all ones or as
  // random bits; bit zero is always set so a stall never lasts the whole mask.
  initial begin
    logic [7:0] ready_mask;
    int         ready_tick;
    m_axis_tready = 1'b0;
    ready_mask    = 8'hFF;
    ready_tick    = 0;
    forever begin
      @(negedge clk_i);
      if (ready_tick % 40 == 0) begin
        ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      m_axis_tready <= ready_mask[ready_tick % 8];
      ready_tick++;
    end
  end

  // Scores every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    fifo_word_t got;
    fifo_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.rd !== want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, got.rd);
          err_count++;
        end
        if (got.acc !== want.acc) begin
          $error("accepted: expected %b, got %b", want.acc, got.acc);
          err_count++;
        end
        if (got.full !== want.full) begin
          $error("is_full: expected %b, got %b", want.full, got.full);
          err_count++;
        end
        if (got.held !== want.held) begin
          $error("words_held: expected %0d, got %0d", want.held, got.held);
          err_count++;
        end
        if (got.pad !== want.pad) begin
          $error("pad bits: expected %h, got %h", want.pad, got.pad);
          err_count++;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sim.f
sv/cfb_pkg.sv
sv/cfb_ctrl.sv
sv/cfb_datapath.sv
sv/circular_fifo_buffer.sv
sim/tb_circular_fifo_buffer.sv
